>>> hw/rtl/memory_moving_inversion_tester_unit_defines.svh
// Assertion macros for the moving-inversion memory tester.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef MEMORY_MOVING_INVERSION_TESTER_UNIT_DEFINES_SVH
`define MEMORY_MOVING_INVERSION_TESTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MMIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define MMIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MMIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/mmit_pkg.sv
// Shared types and constants of the moving-inversion memory tester.
// No dependencies.
`default_nettype none

package mmit_pkg;

  // sequencer phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_INVERT,
    PH_CHECK,
    PH_PASSED,
    PH_FAILED,
    PH_INVALID
  } phase_t;

  // memory command code
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } mem_op_t;

  // reported status
  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_PASSED   = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_INVALID  = 3'd3,
    ST_IDLE     = 3'd4
  } status_t;

  // request action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  // port widths fixed by the interface
  localparam int REG_W = 32;
  localparam int OUT_W = 32;

  // status shown for a phase
  function automatic status_t phase_status(input phase_t ph);
    status_t st;
    unique case (ph)
      PH_FILL, PH_INVERT, PH_CHECK: st = ST_RUNNING;
      PH_PASSED:                    st = ST_PASSED;
      PH_FAILED:                    st = ST_MISMATCH;
      PH_INVALID:                   st = ST_INVALID;
      default:                      st = ST_IDLE;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/memory_moving_inversion_tester_unit.sv
// Moving-inversion memory self-test sequencer, top level.
// Depends on mmit_pkg and memory_moving_inversion_tester_unit_defines.svh.
//
// Usage:
//   cfg_*  : write region_start (index 0) and region_end (index 1) while idle.
//            Alignment to whole words is done when the register is written.
//   in_*   : one request per step. in_action = start restarts the test and
//            already issues the first write for a valid region; in_action = step
//            advances it and carries in_read_data for the read of the previous step.
//   out_*  : one result per request: memory command, address, write data,
//            status and, after a mismatch, the failure report.
// Result: a result appears in the output register in the cycle after its
// request is accepted.
// Throughput: one request per cycle while the result register does not stall;
// the step logic is combinational between the state and result registers.
// Reset: rst_n (synchronous, active low) clears the configuration and state
// registers to zero, the phase to idle and empties the result register.
// Stall: while out_valid is high and out_ready low the result holds and
// in_ready drops; a request is taken in the same cycle the result leaves.
`default_nettype none
`include "memory_moving_inversion_tester_unit_defines.svh"

module memory_moving_inversion_tester_unit import mmit_pkg::*; #(
  parameter int WORD_BYTES = 4,
  parameter int ADDR_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  // requests
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [REG_W-1:0]     in_read_data,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_mem_op,
  output logic [OUT_W-1:0]     out_mem_address,
  output logic [OUT_W-1:0]     out_write_data,
  output logic [2:0]           out_status,
  output logic [OUT_W-1:0]     out_fail_pattern,
  output logic [OUT_W-1:0]     out_fail_data
);

  localparam int DATA_W = WORD_BYTES * 8;
  localparam int WIDE_W = 65;
  localparam logic [ADDR_BITS-1:0] WB_A = ADDR_BITS'(WORD_BYTES);

  // 2^i mod WORD_BYTES, constant argument only
  function automatic logic [2:0] pow2_mod(input int i);
    int r;
    r = 1 % WORD_BYTES;
    for (int k = 0; k < i; k++) r = (r * 2) % WORD_BYTES;
    return 3'(r);
  endfunction

  // address mod WORD_BYTES: fold bit residues twice, then restore
  function automatic logic [2:0] addr_rem(input logic [ADDR_BITS-1:0] v);
    logic [9:0] acc1;
    logic [6:0] acc2;
    logic [9:0] r;
    acc1 = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      if (v[i]) acc1 = acc1 + 10'(pow2_mod(i));
    end
    acc2 = '0;
    for (int j = 0; j < 10; j++) begin
      if (acc1[j]) acc2 = acc2 + 7'(pow2_mod(j));
    end
    r = 10'(acc2);
    for (int k = 6; k >= 0; k--) begin
      if (r >= (10'(WORD_BYTES) << k)) r = r - (10'(WORD_BYTES) << k);
    end
    return r[2:0];
  endfunction

  // configuration: aligned region bounds
  logic [ADDR_BITS-1:0] start_al_r, end_al_r;
  logic [WIDE_W-1:0]    cfg_wide;
  logic [ADDR_BITS-1:0] cfg_addr;
  logic [2:0]           cfg_rem;
  logic [ADDR_BITS-1:0] cfg_up, cfg_down;

  assign cfg_wide = WIDE_W'(cfg_wdata);
  assign cfg_addr = cfg_wide[ADDR_BITS-1:0];
  assign cfg_rem  = addr_rem(cfg_addr);
  assign cfg_up   = (cfg_rem == 3'd0) ? cfg_addr
                                      : cfg_addr + (WB_A - ADDR_BITS'(cfg_rem));
  assign cfg_down = cfg_addr - ADDR_BITS'(cfg_rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_al_r <= '0;
      end_al_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REGION_START: start_al_r <= cfg_up;
        CFG_REGION_END:   end_al_r   <= cfg_down;
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_t               phase_r, phase_nxt;
  logic [ADDR_BITS-1:0] idx_r, idx_nxt;
  logic [ADDR_BITS-1:0] off_r, off_nxt;
  logic                 pend_r, pend_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [ADDR_BITS-1:0] span_r, span_nxt;
  logic [DATA_W-1:0]    fail_exp_r, fail_exp_nxt;
  logic [REG_W-1:0]     fail_act_r, fail_act_nxt;
  logic [ADDR_BITS-1:0] fail_addr_r, fail_addr_nxt;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // step operands: the registered state, or the state as seen after a start request
  logic                 start, region_ok;
  phase_t               eff_phase;
  logic [ADDR_BITS-1:0] eff_idx, eff_off, eff_base, eff_span;
  logic                 eff_pend;
  logic [ADDR_BITS-1:0] cur_addr, off_inc, idx_inc;
  logic                 last;
  logic [WIDE_W-1:0]    pat_wide, rd_wide;
  logic [DATA_W-1:0]    pat, expect_val, got;
  logic                 match;

  always_comb begin
    start     = (in_action == ACT_START);
    region_ok = end_al_r > start_al_r;
    if (start) begin
      eff_phase = region_ok ? PH_FILL : PH_INVALID;
      eff_idx   = '0;
      eff_off   = '0;
      eff_pend  = 1'b0;
      eff_base  = region_ok ? start_al_r : base_r;
      eff_span  = region_ok ? (end_al_r - start_al_r) : '0;
    end else begin
      eff_phase = phase_r;
      eff_idx   = idx_r;
      eff_off   = off_r;
      eff_pend  = pend_r;
      eff_base  = base_r;
      eff_span  = span_r;
    end
    cur_addr   = eff_base + eff_off;
    off_inc    = eff_off + WB_A;
    idx_inc    = eff_idx + ADDR_BITS'(1);
    last       = off_inc >= eff_span;
    pat_wide   = WIDE_W'(eff_idx) + WIDE_W'(1);
    pat        = pat_wide[DATA_W-1:0];
    expect_val = (eff_phase == PH_INVERT) ? pat : ~pat;
    rd_wide    = WIDE_W'(in_read_data);
    got        = rd_wide[DATA_W-1:0];
    match      = (got == expect_val);
  end

  // next state
  always_comb begin
    phase_nxt     = eff_phase;
    idx_nxt       = eff_idx;
    off_nxt       = eff_off;
    pend_nxt      = eff_pend;
    base_nxt      = eff_base;
    span_nxt      = eff_span;
    fail_exp_nxt  = start ? '0 : fail_exp_r;
    fail_act_nxt  = start ? '0 : fail_act_r;
    fail_addr_nxt = start ? '0 : fail_addr_r;
    unique case (eff_phase) inside
      PH_FILL: begin
        idx_nxt = idx_inc;
        off_nxt = off_inc;
        if (last) begin
          idx_nxt   = '0;
          off_nxt   = '0;
          phase_nxt = PH_INVERT;
        end
      end
      PH_INVERT, PH_CHECK: begin
        if (!eff_pend) begin
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!match) begin
            phase_nxt     = PH_FAILED;
            fail_exp_nxt  = expect_val;
            fail_act_nxt  = in_read_data;
            fail_addr_nxt = cur_addr;
          end else begin
            idx_nxt = idx_inc;
            off_nxt = off_inc;
            if (last) begin
              idx_nxt   = '0;
              off_nxt   = '0;
              phase_nxt = (eff_phase == PH_INVERT) ? PH_CHECK : PH_PASSED;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result fields
  mem_op_t              res_op;
  logic [ADDR_BITS-1:0] res_addr_a;
  logic [DATA_W-1:0]    res_wdata_d, res_exp_d;
  logic [WIDE_W-1:0]    addr_wide, wdata_wide, exp_wide;
  logic [OUT_W-1:0]     res_addr, res_wdata, res_exp, res_act;
  status_t              res_status;

  always_comb begin
    res_op      = OP_NONE;
    res_addr_a  = '0;
    res_wdata_d = '0;
    unique case (eff_phase) inside
      PH_FILL: begin
        res_op      = OP_WRITE;
        res_addr_a  = cur_addr;
        res_wdata_d = pat;
      end
      PH_INVERT, PH_CHECK: begin
        if (!eff_pend) begin
          res_op     = OP_READ;
          res_addr_a = cur_addr;
        end else if (match) begin
          res_op      = OP_WRITE;
          res_addr_a  = cur_addr;
          res_wdata_d = (eff_phase == PH_INVERT) ? ~pat : '0;
        end
      end
      default: ;
    endcase
    if (phase_nxt == PH_FAILED) res_addr_a = fail_addr_nxt;
    res_exp_d  = (phase_nxt == PH_FAILED) ? fail_exp_nxt : '0;
    res_act    = (phase_nxt == PH_FAILED) ? fail_act_nxt : '0;
    res_status = phase_status(phase_nxt);
    addr_wide  = WIDE_W'(res_addr_a);
    wdata_wide = WIDE_W'(res_wdata_d);
    exp_wide   = WIDE_W'(res_exp_d);
    res_addr   = addr_wide[OUT_W-1:0];
    res_wdata  = wdata_wide[OUT_W-1:0];
    res_exp    = exp_wide[OUT_W-1:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= 1'b0;
      idx_r   <= '0;
      off_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
      off_r   <= off_nxt;
    end
  end

  // region and failure report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      span_r      <= '0;
      fail_exp_r  <= '0;
      fail_act_r  <= '0;
      fail_addr_r <= '0;
    end else if (in_acc) begin
      base_r      <= base_nxt;
      span_r      <= span_nxt;
      fail_exp_r  <= fail_exp_nxt;
      fail_act_r  <= fail_act_nxt;
      fail_addr_r <= fail_addr_nxt;
    end
  end

  // result register
  logic             out_valid_r;
  mem_op_t          out_mem_op_r;
  logic [OUT_W-1:0] out_mem_address_r, out_write_data_r;
  logic [OUT_W-1:0] out_fail_pattern_r, out_fail_data_r;
  status_t          out_status_r;

  assign in_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_mem_op_r       <= res_op;
      out_mem_address_r  <= res_addr;
      out_write_data_r   <= res_wdata;
      out_status_r       <= res_status;
      out_fail_pattern_r <= res_exp;
      out_fail_data_r    <= res_act;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mem_op       = out_mem_op_r;
  assign out_mem_address  = out_mem_address_r;
  assign out_write_data   = out_write_data_r;
  assign out_status       = out_status_r;
  assign out_fail_pattern = out_fail_pattern_r;
  assign out_fail_data    = out_fail_data_r;

  // checks
  `MMIT_ASSERT_IMPLY(a_pend_in_read_pass, clk, rst_n, pend_r,
    (phase_r == PH_INVERT || phase_r == PH_CHECK), "read pending outside a read pass")
  `MMIT_ASSERT_IMPLY(a_off_in_span, clk, rst_n,
    (phase_r == PH_FILL || phase_r == PH_INVERT || phase_r == PH_CHECK),
    (off_r < span_r), "word offset beyond region")
  `MMIT_ASSERT_IMPLY(a_fail_no_op, clk, rst_n,
    (out_valid_r && out_status_r == ST_MISMATCH), (out_mem_op_r == OP_NONE),
    "memory command issued with mismatch status")
  `MMIT_ASSERT_NEXT(a_read_issued, clk, rst_n,
    (in_acc && in_action == ACT_STEP && !pend_r &&
     (phase_r == PH_INVERT || phase_r == PH_CHECK)),
    (out_mem_op_r == OP_READ), "read pass step without a read command")

endmodule

`default_nettype wire
